/* hw/rtl/rgbhsv_pkg.sv */
package rgbhsv_pkg;

    // default geometry
    localparam int unsigned COMPONENT_BITS = 8;
    localparam int unsigned HUE_FRAC_BITS  = 6;

    // hue sector, chosen red first, then green, then blue
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

/* hw/rtl/rgbhsv_pix_if.sv */
interface rgbhsv_pix_if #(
    parameter int unsigned COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS
);
    logic                      valid;
    logic                      ready;
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/rgbhsv_res_if.sv */
interface rgbhsv_res_if #(
    parameter int unsigned COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS,
    parameter int unsigned HUE_FRAC_BITS  = rgbhsv_pkg::HUE_FRAC_BITS
);
    logic                       valid;
    logic                       ready;
    logic [HUE_FRAC_BITS+8:0]   hue;
    logic [COMPONENT_BITS-1:0]  saturation;
    logic [COMPONENT_BITS-1:0]  brightness;
    logic                       grey;

    modport source (output valid, output hue, output saturation, output brightness,
                    output grey, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input grey, output ready);
endinterface

/* hw/rtl/rgb_to_hsv_pixel_converter.sv */
// Channel  Dir  Handshake      Word
// i_pix    in   valid / ready  red, green, blue (COMPONENT_BITS each)
// o_hsv    out  valid / ready  hue (9+HUE_FRAC_BITS), saturation, brightness, grey
//
// One pixel per cycle sustained while o_hsv is not stalled. The two restoring dividers
// (saturation and hue) resolve one quotient bit per stage, with QW = max(COMPONENT_BITS,
// 6+HUE_FRAC_BITS) quotient bits.
// Reset (i_rst_n low, synchronous) clears the valid bits only.
// A stall at o_hsv freezes every stage at once; i_pix.ready drops in the same cycle.
module rgb_to_hsv_pixel_converter #(
    parameter int unsigned COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS,
    parameter int unsigned HUE_FRAC_BITS  = rgbhsv_pkg::HUE_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rgbhsv_pix_if.sink          i_pix,
    rgbhsv_res_if.source        o_hsv
);
    import rgbhsv_pkg::*;

    localparam int unsigned N    = COMPONENT_BITS;
    localparam int unsigned F    = HUE_FRAC_BITS;
    localparam int unsigned HW   = F + 9;                      // hue width
    localparam int unsigned QW   = (N > F + 6) ? N : F + 6;    // quotient bits = div stages
    localparam int unsigned DW   = N + QW;                     // dividend / remainder width
    localparam int unsigned LAST = QW + 2;                     // index of output stage

    // hue sector bases, D = 60 degrees in hue units
    localparam logic [HW-1:0] HUE_D2 = HW'(120 << F);
    localparam logic [HW-1:0] HUE_D4 = HW'(240 << F);
    localparam logic [HW-1:0] HUE_D6 = HW'(360 << F);

    typedef struct packed {
        logic [N-1:0]  mx;      // brightness, saturation divisor
        logic [N-1:0]  delta;   // hue divisor
        t_sector       sec;
        logic          neg;     // hue offset is negative
        logic          grey;
        logic [DW-1:0] srem;
        logic [DW-1:0] hrem;
        logic [QW-1:0] sq;
        logic [QW-1:0] hq;
    } t_div;

    // valid bits, one per stage
    logic [LAST:0] r_vld;
    logic          w_adv;

    assign w_adv       = !r_vld[LAST] || o_hsv.ready;
    assign i_pix.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAST-1:0], i_pix.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: max, min, sector and the two operands of the hue offset
    // ------------------------------------------------------------------
    logic [N-1:0] w_r, w_g, w_b;
    logic [N-1:0] w_mx_rg, w_mn_rg;
    logic [N-1:0] n1_mx, n1_mn, n1_a, n1_b;
    t_sector      n1_sec;
    logic [N-1:0] r1_mx, r1_mn, r1_a, r1_b;
    t_sector      r1_sec;

    always_comb begin
        w_r     = N'(i_pix.red);
        w_g     = N'(i_pix.green);
        w_b     = N'(i_pix.blue);
        w_mx_rg = (w_r > w_g) ? w_r : w_g;
        w_mn_rg = (w_r < w_g) ? w_r : w_g;
        n1_mx   = (w_b > w_mx_rg) ? w_b : w_mx_rg;
        n1_mn   = (w_b < w_mn_rg) ? w_b : w_mn_rg;
        if (w_r >= n1_mx) begin
            n1_sec = SEC_RED;
            n1_a   = w_g;
            n1_b   = w_b;
        end else if (w_g >= n1_mx) begin
            n1_sec = SEC_GREEN;
            n1_a   = w_b;
            n1_b   = w_r;
        end else begin
            n1_sec = SEC_BLUE;
            n1_a   = w_r;
            n1_b   = w_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mx  <= n1_mx;
            r1_mn  <= n1_mn;
            r1_a   <= n1_a;
            r1_b   <= n1_b;
            r1_sec <= n1_sec;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: delta, |offset|, dividends CMAX*delta and D*|offset|
    // ------------------------------------------------------------------
    t_div         r_dv [QW+1];
    t_div         n_dv [QW+1];
    logic [N-1:0] w_ad;
    logic [N-1:0] w_delta;

    always_comb begin
        w_delta       = r1_mx - r1_mn;
        w_ad          = (r1_a < r1_b) ? (r1_b - r1_a) : (r1_a - r1_b);
        n_dv[0].mx    = r1_mx;
        n_dv[0].delta = w_delta;
        n_dv[0].sec   = r1_sec;
        n_dv[0].neg   = (r1_a < r1_b);
        n_dv[0].grey  = (w_delta == '0);
        // (2^N - 1)*delta = (delta << N) - delta
        n_dv[0].srem  = (DW'(w_delta) << N) - DW'(w_delta);
        // 60*2^F*x = (x << (F+6)) - (x << (F+2))
        n_dv[0].hrem  = (DW'(w_ad) << (F + 6)) - (DW'(w_ad) << (F + 2));
        n_dv[0].sq    = '0;
        n_dv[0].hq    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0] <= n_dv[0];
        end
    end

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int unsigned SH = QW - 1 - k;
        logic [DW-1:0] w_sd, w_hd;

        always_comb begin
            w_sd      = DW'(r_dv[k].mx) << SH;
            w_hd      = DW'(r_dv[k].delta) << SH;
            n_dv[k+1] = r_dv[k];
            if (r_dv[k].srem >= w_sd) begin
                n_dv[k+1].srem   = r_dv[k].srem - w_sd;
                n_dv[k+1].sq[SH] = 1'b1;
            end
            if (r_dv[k].hrem >= w_hd) begin
                n_dv[k+1].hrem   = r_dv[k].hrem - w_hd;
                n_dv[k+1].hq[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k+1] <= n_dv[k+1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sector base, floor of negative offset, wrap
    // ------------------------------------------------------------------
    t_div          w_q;
    logic [HW-1:0] w_mag, w_base;
    logic [HW-1:0] n_hue;
    logic [N-1:0]  n_sat;
    logic [HW-1:0] r_hue;
    logic [N-1:0]  r_sat, r_bri;
    logic          r_grey;

    always_comb begin
        w_q = r_dv[QW];
        // floor of a negative quotient rounds away from zero
        w_mag = HW'(w_q.hq) + HW'(w_q.neg && (w_q.hrem != '0));
        case (w_q.sec)
            SEC_RED:   w_base = w_q.neg ? HUE_D6 : '0;   // negative red hue wraps
            SEC_GREEN: w_base = HUE_D2;
            default:   w_base = HUE_D4;
        endcase
        n_hue = w_q.neg ? (w_base - w_mag) : (w_base + w_mag);
        n_sat = N'(w_q.sq);
        if (w_q.grey) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hue  <= n_hue;
            r_sat  <= n_sat;
            r_bri  <= w_q.mx;
            r_grey <= w_q.grey;
        end
    end

    assign o_hsv.valid      = r_vld[LAST];
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_bri;
    assign o_hsv.grey       = r_grey;

endmodule

/* dv/rgb_to_hsv_pixel_converter_checker.sv */
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_converter_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rgbhsv_pix_if  pix,
    rgbhsv_res_if  hsv,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked,
    output int     o_grey_seen
);
    import rgbhsv_pkg::*;

    localparam int CW       = COMPONENT_BITS;
    localparam int HW       = HUE_FRAC_BITS + 9;
    localparam int CMAX     = (1 << CW) - 1;
    localparam int HUE_STEP = 60 << HUE_FRAC_BITS;  // 60 degrees in hue units

    typedef struct packed {
        logic [HW-1:0] hue;
        logic [CW-1:0] sat;
        logic [CW-1:0] val;
        logic          grey;
    } t_hsv_word;

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        t_hsv_word     hsv;
    } t_hsv_expect;

    t_hsv_expect hsv_expected_q[$];
    int          fails   = 0;
    int          checked = 0;
    int          greys   = 0;

    // rounds toward minus infinity, den > 0
    function automatic int floor_quot(input int num, input int den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic t_hsv_word hsv_of_pixel(input logic [CW-1:0] r8,
                                               input logic [CW-1:0] g8,
                                               input logic [CW-1:0] b8);
        int        r, g, b, mx, mn, delta, h;
        t_sector   sec;
        t_hsv_word w;
        r     = r8;
        g     = g8;
        b     = b8;
        mx    = (r > g) ? r : g;
        mn    = (r < g) ? r : g;
        mx    = (b > mx) ? b : mx;
        mn    = (b < mn) ? b : mn;
        delta = mx - mn;
        w     = '0;
        w.val = CW'(mx);
        if (delta == 0) begin
            w.grey = 1'b1;
            return w;
        end
        w.sat = CW'((CMAX * delta) / mx);
        if (r == mx)
            sec = SEC_RED;
        else if (g == mx)
            sec = SEC_GREEN;
        else
            sec = SEC_BLUE;
        case (sec)
            SEC_RED:   h = floor_quot(HUE_STEP * (g - b), delta);
            SEC_GREEN: h = 2 * HUE_STEP + floor_quot(HUE_STEP * (b - r), delta);
            default:   h = 4 * HUE_STEP + floor_quot(HUE_STEP * (r - g), delta);
        endcase
        if (h < 0)
            h += 6 * HUE_STEP;
        w.hue = HW'(h);
        return w;
    endfunction

    task automatic note_fail(input string what, input t_hsv_expect e, input t_hsv_word got);
        fails++;
        if (fails <= 10) begin
            $display("%0t mismatch: %s rgb=(%0d,%0d,%0d)", $realtime, what, e.r, e.g, e.b);
            $display("    exp hue=%0d sat=%0d val=%0d grey=%0d",
                     e.hsv.hue, e.hsv.sat, e.hsv.val, e.hsv.grey);
            $display("    got hue=%0d sat=%0d val=%0d grey=%0d",
                     got.hue, got.sat, got.val, got.grey);
        end
    endtask

    always @(posedge i_clk) begin
        t_hsv_expect e;
        t_hsv_word   got;
        if (i_rst_n) begin
            if (pix.valid && pix.ready) begin
                e.r   = pix.red;
                e.g   = pix.green;
                e.b   = pix.blue;
                e.hsv = hsv_of_pixel(pix.red, pix.green, pix.blue);
                hsv_expected_q.insert(hsv_expected_q.size(), e);
            end
            if (hsv.valid && hsv.ready) begin
                got.hue  = hsv.hue;
                got.sat  = hsv.saturation;
                got.val  = hsv.brightness;
                got.grey = hsv.grey;
                checked++;
                if (hsv_expected_q.size() == 0) begin
                    e = '0;
                    note_fail("word with nothing pending", e, got);
                end else begin
                    e = hsv_expected_q.pop_front();
                    if (e.hsv.grey)
                        greys++;
                    if (got.hue !== e.hsv.hue || got.sat !== e.hsv.sat ||
                        got.val !== e.hsv.val || got.grey !== e.hsv.grey)
                        note_fail("field", e, got);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= hsv_expected_q.size();
        o_checked    <= checked;
        o_grey_seen  <= greys;
    end

endmodule

/* dv/rgb_to_hsv_pixel_converter_tb.sv */
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_converter_tb;
    import rgbhsv_pkg::*;

    localparam int CW        = COMPONENT_BITS;
    localparam int CMAX      = (1 << CW) - 1;
    localparam int N_RANDOM  = 1750;
    // worst case per pixel is the longest sender gap plus the longest sink
    // stall, over ~1800 pixels; keep a wide margin
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
    } t_rgb;

    logic i_clk;
    logic i_rst_n;
    bit   steady      = 1'b0;  // when set, neither side idles
    int   cycle_count = 0;
    int   pixels_sent = 0;
    int   stall_left  = 0;
    int   fail_count;
    int   pending;
    int   checked;
    int   grey_seen;

    rgbhsv_pix_if pix_ch ();
    rgbhsv_res_if hsv_ch ();

    rgb_to_hsv_pixel_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_hsv   (hsv_ch)
    );

    // scoreboard sits beside the DUT and watches both channels
    rgb_to_hsv_pixel_converter_checker u_hsv_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix_ch),
        .hsv          (hsv_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_grey_seen  (grey_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending", cycle_count, pending);
            $display("[rgb_to_hsv_pixel_converter] ERROR");
            $finish;
        end
    end

    // gap length: mostly short, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // sink side: random back-pressure on o_hsv, none while steady
    always @(negedge i_clk) begin
        if (steady) begin
            stall_left = 0;
            hsv_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            hsv_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < 20) begin
            stall_left = gap_length() - 1;
            hsv_ch.ready <= 1'b0;
        end else begin
            hsv_ch.ready <= 1'b1;
        end
    end

    // drive one word and hold it until the handshake completes;
    // valid stays high into the next word unless a pause lowers it
    task automatic push_pixel(input t_rgb p);
        @(negedge i_clk);
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= p.r;
        pix_ch.green <= p.g;
        pix_ch.blue  <= p.b;
        do
            @(posedge i_clk);
        while (pix_ch.ready !== 1'b1);
        pixels_sent++;
    endtask

    // valid low for the given gap, payload scrambled so it must be ignored
    task automatic pause(input int n);
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        pix_ch.red   <= CW'($urandom);
        pix_ch.green <= CW'($urandom);
        pix_ch.blue  <= CW'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_paced(input t_rgb p);
        push_pixel(p);
        if (!steady && $urandom_range(99) < 30)
            pause(gap_length());
    endtask

    // hold off the sender until every expected word is back
    task automatic drain();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int near_value(input int base);
        int v;
        v = base + $urandom_range(4) - 2;
        return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
    endfunction

    function automatic int pick_extreme();
        int sel;
        sel = $urandom_range(2);
        return (sel == 0) ? 0 : (sel == 1) ? CMAX : $urandom_range(CMAX);
    endfunction

    // random pixel from a mix of shapes: uniform, grey, near-grey, two-way
    // ties for the max, rails, one dominant channel, and tiny values
    function automatic t_rgb random_pixel();
        int   c[3];
        int   hi, base, rot, tmp, which;
        t_rgb p;
        case ($urandom_range(9))
            4: begin
                c[0] = $urandom_range(CMAX);
                c[1] = c[0];
                c[2] = c[0];
            end
            5: begin
                base = $urandom_range(CMAX);
                c[0] = near_value(base);
                c[1] = near_value(base);
                c[2] = near_value(base);
            end
            6: begin
                hi    = $urandom_range(1, CMAX);
                which = $urandom_range(2);
                c[0]  = hi;
                c[1]  = hi;
                c[2]  = hi;
                c[which] = $urandom_range(hi - 1);
            end
            7: begin
                c[0] = pick_extreme();
                c[1] = pick_extreme();
                c[2] = pick_extreme();
            end
            8: begin
                hi   = $urandom_range(CMAX / 2, CMAX);
                c[0] = hi;
                c[1] = $urandom_range(hi);
                c[2] = near_value(c[1]);
                if (c[2] > hi)
                    c[2] = hi;
            end
            9: begin
                c[0] = $urandom_range(3);
                c[1] = $urandom_range(3);
                c[2] = $urandom_range(3);
            end
            default: begin
                c[0] = $urandom_range(CMAX);
                c[1] = $urandom_range(CMAX);
                c[2] = $urandom_range(CMAX);
            end
        endcase
        // shuffle channel roles so each shape lands in every sector
        if ($urandom_range(1)) begin
            tmp  = c[1];
            c[1] = c[2];
            c[2] = tmp;
        end
        rot = $urandom_range(2);
        p.r = CW'(c[rot]);
        p.g = CW'(c[(rot + 1) % 3]);
        p.b = CW'(c[(rot + 2) % 3]);
        return p;
    endfunction

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        i_rst_n      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: grey incl. black and white, primaries, sector ties
        // (red wins over green and blue, green over blue), hue wrap below
        // zero, full and minimum saturation, sign of the offset per sector
        send_paced('{r: 0,    g: 0,    b: 0});
        send_paced('{r: CMAX, g: CMAX, b: CMAX});
        send_paced('{r: 128,  g: 128,  b: 128});
        send_paced('{r: 1,    g: 1,    b: 1});
        send_paced('{r: CMAX, g: 0,    b: 0});
        send_paced('{r: 0,    g: CMAX, b: 0});
        send_paced('{r: 0,    g: 0,    b: CMAX});
        send_paced('{r: CMAX, g: CMAX, b: 0});
        send_paced('{r: 0,    g: CMAX, b: CMAX});
        send_paced('{r: CMAX, g: 0,    b: CMAX});
        send_paced('{r: CMAX, g: 0,    b: 1});
        send_paced('{r: CMAX, g: 1,    b: 0});
        send_paced('{r: CMAX, g: 0,    b: 254});
        send_paced('{r: 1,    g: 0,    b: 0});
        send_paced('{r: CMAX, g: 254,  b: 254});
        send_paced('{r: 254,  g: CMAX, b: CMAX});
        send_paced('{r: 0,    g: CMAX, b: 1});
        send_paced('{r: 1,    g: CMAX, b: 0});
        send_paced('{r: 1,    g: 0,    b: CMAX});
        send_paced('{r: 0,    g: 1,    b: CMAX});
        send_paced('{r: CMAX, g: 128,  b: 0});
        send_paced('{r: 170,  g: 85,   b: 0});
        send_paced('{r: 200,  g: 100,  b: 150});
        send_paced('{r: 37,   g: 201,  b: 119});

        // sender holds off until the pipe is empty
        drain();

        for (int k = 0; k < N_RANDOM; k++) begin
            // a stretch of back-to-back traffic in each full block of 500 pixels
            steady = ((k % 500) >= 300) && ((k % 500) < 420);
            if (k == N_RANDOM / 2)
                drain();
            send_paced(random_pixel());
        end

        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d pixels: directed corners plus random mixes of grey, near-grey,",
                 pixels_sent);
        $display("tied, rail and dominant-channel colors; %0d words checked, %0d of them grey",
                 checked, grey_seen);
        if (fail_count == 0) begin
            $display("[rgb_to_hsv_pixel_converter] OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[rgb_to_hsv_pixel_converter] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_pix_if.sv
hw/rtl/rgbhsv_res_if.sv
hw/rtl/rgb_to_hsv_pixel_converter.sv
dv/rgb_to_hsv_pixel_converter_checker.sv
dv/rgb_to_hsv_pixel_converter_tb.sv
